FILE: rtl/tdp_pkg.sv
// Shared types and constants of the trapezoid distance profile block.
package tdp_pkg;

    localparam int TICK_BITS  = 24;
    localparam int TIME_W     = TICK_BITS + 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TARGET = 2'd0,
        CFG_SPEED  = 2'd1,
        CFG_ACCEL  = 2'd2,
        CFG_PERIOD = 2'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        PH_ACCEL  = 2'd0,
        PH_CRUISE = 2'd1,
        PH_DECEL  = 2'd2,
        PH_DONE   = 2'd3
    } phase_t;

    typedef enum logic [3:0] {
        P_LOAD,
        P_MUL,
        P_CMP,
        P_SQRT,
        P_DIV1,
        P_DIV2,
        P_HALF_HI,
        P_HALF_LO,
        P_HALF_SUM,
        P_READY
    } plan_state_t;

    typedef struct packed {
        logic        ready;
        logic        neg;
        logic [31:0] target;
        logic [31:0] distance;
        logic [30:0] accel;
        logic [30:0] vpeak;
        logic [63:0] t1;
        logic [63:0] t2;
        logic [63:0] t12;
        logic [31:0] half;
        logic [31:0] period;
    } plan_t;

endpackage

FILE: rtl/tdp_if.sv
// Valid/ready channel interfaces for tick items and setpoint items.
interface tdp_in_if;
    import tdp_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [TICK_BITS-1:0] tick_index;

    modport source (output valid, output tick_index, input ready);
    modport sink (input valid, input tick_index, output ready);
endinterface

interface tdp_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] position_setpoint;
    logic [1:0]         phase;

    modport source (output valid, output position_setpoint, output phase, input ready);
    modport sink (input valid, input position_setpoint, input phase, output ready);
endinterface

FILE: rtl/tdp_plan.sv
// Configuration registers and the multi-cycle move planner (sqrt, divides).
module tdp_plan (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [tdp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tdp_pkg::CFG_DATA_W-1:0]     cfg_data,
    output tdp_pkg::plan_t                     plan
);
    import tdp_pkg::*;

    logic [31:0] target_reg;
    logic [30:0] speed_reg;
    logic [30:0] accel_reg;
    logic [31:0] period_reg;

    plan_state_t state_reg, state_next;

    logic        neg_reg;
    logic [31:0] d_reg;
    logic [30:0] v_reg;
    logic [30:0] a_reg;
    logic [62:0] da_reg;
    logic [61:0] vv_reg;
    logic        tri_reg;
    logic [63:0] rem_reg;
    logic [63:0] root_reg;
    logic [63:0] bit_reg;
    logic [5:0]  cnt_reg;
    logic [30:0] vp_reg;
    logic [63:0] quo_reg;
    logic [30:0] drem_reg;
    logic [31:0] dden_reg;
    logic [63:0] t1_reg;
    logic [63:0] t2_reg;
    logic [63:0] t12_reg;
    logic [62:0] hi_reg;
    logic [62:0] lo_reg;
    logic [31:0] half_reg;

    logic        cmp_tri;
    logic [63:0] sq_trial;
    logic        sq_ge;
    logic [63:0] sq_rem;
    logic [63:0] sq_root;
    logic [31:0] div_sh;
    logic        div_ge;
    logic [30:0] div_rem;
    logic [63:0] quo_next;
    logic [63:0] half_sum;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= 32'd0;
            speed_reg  <= 31'd65536;
            accel_reg  <= 31'd65536000;
            period_reg <= 32'd4294967;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_TARGET: target_reg <= cfg_data;
                CFG_SPEED:  speed_reg  <= cfg_data[30:0];
                CFG_ACCEL:  accel_reg  <= cfg_data[30:0];
                CFG_PERIOD: period_reg <= cfg_data;
                default:    target_reg <= target_reg;
            endcase
        end
    end

    assign cmp_tri  = da_reg < {1'b0, vv_reg};
    assign sq_trial = root_reg + bit_reg;
    assign sq_ge    = rem_reg >= sq_trial;
    assign sq_rem   = sq_ge ? rem_reg - sq_trial : rem_reg;
    assign sq_root  = sq_ge ? (root_reg >> 1) + bit_reg : root_reg >> 1;
    assign div_sh   = {drem_reg, quo_reg[63]};
    assign div_ge   = div_sh >= dden_reg;
    assign div_rem  = div_ge ? 31'(div_sh - dden_reg) : div_sh[30:0];
    assign quo_next = {quo_reg[62:0], div_ge};
    assign half_sum = (64'(hi_reg) + 64'(lo_reg[62:32])) >> 1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= P_LOAD;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            P_LOAD:     state_next = P_MUL;
            P_MUL:      state_next = P_CMP;
            P_CMP:      state_next = cmp_tri ? P_SQRT : P_DIV1;
            P_SQRT:     state_next = (cnt_reg == 6'd0) ? P_DIV1 : P_SQRT;
            P_DIV1:
            begin
                if (cnt_reg == 6'd0)
                    state_next = tri_reg ? P_HALF_HI : P_DIV2;
            end
            P_DIV2:     state_next = (cnt_reg == 6'd0) ? P_HALF_HI : P_DIV2;
            P_HALF_HI:  state_next = P_HALF_LO;
            P_HALF_LO:  state_next = P_HALF_SUM;
            P_HALF_SUM: state_next = P_READY;
            P_READY:    state_next = P_READY;
            default:    state_next = P_LOAD;
        endcase
        // any register write restarts the plan
        if (cfg_we)
            state_next = P_LOAD;
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            P_LOAD:
            begin
                neg_reg <= target_reg[31];
                d_reg   <= target_reg[31] ? 32'(-target_reg) : target_reg;
                v_reg   <= (speed_reg == 31'd0) ? 31'd1 : speed_reg;
                a_reg   <= (accel_reg == 31'd0) ? 31'd1 : accel_reg;
            end
            P_MUL:
            begin
                da_reg <= d_reg * a_reg;
                vv_reg <= v_reg * v_reg;
            end
            P_CMP:
            begin
                tri_reg  <= cmp_tri;
                rem_reg  <= 64'(da_reg);
                root_reg <= 64'd0;
                bit_reg  <= 64'd1 << 62;
                if (cmp_tri)
                    cnt_reg <= 6'd31;
                else
                begin
                    vp_reg   <= v_reg;
                    quo_reg  <= {1'b0, v_reg, 32'd0};
                    drem_reg <= 31'd0;
                    dden_reg <= {1'b0, a_reg};
                    cnt_reg  <= 6'd63;
                end
            end
            P_SQRT:
            begin
                rem_reg  <= sq_rem;
                root_reg <= sq_root;
                bit_reg  <= bit_reg >> 2;
                cnt_reg  <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd0)
                begin
                    vp_reg   <= sq_root[30:0];
                    quo_reg  <= {1'b0, sq_root[30:0], 32'd0};
                    drem_reg <= 31'd0;
                    dden_reg <= {1'b0, a_reg};
                    cnt_reg  <= 6'd63;
                end
            end
            P_DIV1:
            begin
                quo_reg  <= quo_next;
                drem_reg <= div_rem;
                cnt_reg  <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd0)
                begin
                    t1_reg <= quo_next;
                    t2_reg <= quo_next;
                    quo_reg  <= {d_reg, 32'd0};
                    drem_reg <= 31'd0;
                    dden_reg <= {1'b0, v_reg};
                    cnt_reg  <= 6'd63;
                end
            end
            P_DIV2:
            begin
                quo_reg  <= quo_next;
                drem_reg <= div_rem;
                cnt_reg  <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd0)
                    t2_reg <= quo_next;
            end
            P_HALF_HI:  hi_reg <= vp_reg * t1_reg[63:32];
            P_HALF_LO:
            begin
                lo_reg  <= vp_reg * t1_reg[31:0];
                t12_reg <= t1_reg + t2_reg;
            end
            P_HALF_SUM: half_reg <= half_sum[31:0];
            P_READY:    half_reg <= half_reg;
            default:    half_reg <= half_reg;
        endcase
    end

    assign plan.ready    = (state_reg == P_READY);
    assign plan.neg      = neg_reg;
    assign plan.target   = target_reg;
    assign plan.distance = d_reg;
    assign plan.accel    = a_reg;
    assign plan.vpeak    = vp_reg;
    assign plan.t1       = t1_reg;
    assign plan.t2       = t2_reg;
    assign plan.t12      = t12_reg;
    assign plan.half     = half_reg;
    assign plan.period   = period_reg;

endmodule

FILE: rtl/tdp_pipe.sv
// Seven-stage tick pipeline: time, phase select, products, clamp and sign.
module tdp_pipe (
    input  logic           clk,
    input  logic           rst_n,
    input  tdp_pkg::plan_t plan,
    tdp_in_if.sink         in_ch,
    tdp_out_if.source      out_ch
);
    import tdp_pkg::*;

    localparam int NST = 7;
    localparam int SW  = TIME_W + 2;

    logic [NST:1]   valid_reg;
    logic [NST+1:1] en;
    logic           accept;

    logic [TIME_W-1:0] t_in;
    logic [TIME_W-1:0] t1s_reg;

    logic [63:0]       t64;
    phase_t            ph_sel;
    logic [TIME_W-1:0] x_sel;
    phase_t            ph2_reg, ph3_reg, ph4_reg, ph5_reg, ph6_reg;
    logic [TIME_W-1:0] x2_reg, dt2_reg, x3_reg, x4_reg;

    logic [TIME_W-2:0] ah3_reg, ch3_reg;
    logic [62:0]       al3_reg, cl3_reg;
    logic [TIME_W-1:0] sp4_reg, c4_reg, c5_reg, c6_reg;
    logic [TIME_W-1:0] qh5_reg;
    logic [63:0]       ql5_reg;
    logic [TIME_W:0]   q_sum;
    logic [TIME_W-1:0] q6_reg;

    logic [SW-1:0]     s_sum;
    logic [SW-1:0]     s_diff;
    logic [SW-1:0]     s_mag;
    logic [31:0]       m32;
    logic [31:0]       pos_reg;
    phase_t            ph7_reg;

    // a stage moves when it is empty or the next one moves
    always_comb
    begin
        en[NST+1] = out_ch.ready;
        for (int k = NST; k >= 1; k--)
            en[k] = !valid_reg[k] || en[k+1];
    end

    assign in_ch.ready = en[1] && plan.ready;
    assign accept      = in_ch.valid && in_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
        begin
            if (en[1])
                valid_reg[1] <= accept;
            for (int k = 2; k <= NST; k++)
                if (en[k])
                    valid_reg[k] <= valid_reg[k-1];
        end
    end

    assign t_in = in_ch.tick_index * plan.period;

    assign t64 = 64'(t1s_reg);
    always_comb
    begin
        priority if (t64 < plan.t1)
            ph_sel = PH_ACCEL;
        else if (t64 > plan.t12)
            ph_sel = PH_DONE;
        else if (t64 > plan.t2)
            ph_sel = PH_DECEL;
        else
            ph_sel = PH_CRUISE;
    end
    assign x_sel = (ph_sel == PH_ACCEL) ? t1s_reg : TIME_W'(t64 - plan.t2);

    assign q_sum = (TIME_W+1)'(qh5_reg) + (TIME_W+1)'(ql5_reg[63:32]);

    // final magnitude: accel q, cruise half + c, decel half + c - q
    assign s_sum  = SW'(plan.half) + SW'(c6_reg);
    assign s_diff = s_sum - ((ph6_reg == PH_DECEL) ? SW'(q6_reg) : SW'(0));
    always_comb
    begin
        s_mag = (ph6_reg == PH_ACCEL) ? SW'(q6_reg) : s_diff;
        if (s_mag[SW-1])
            s_mag = '0;
        else if (s_mag > SW'(plan.distance))
            s_mag = SW'(plan.distance);
    end
    assign m32 = s_mag[31:0];

    always_ff @(posedge clk)
    begin
        if (en[1])
            t1s_reg <= t_in;
        if (en[2])
        begin
            ph2_reg <= ph_sel;
            x2_reg  <= x_sel;
            dt2_reg <= TIME_W'(t64 - plan.t1);
        end
        if (en[3])
        begin
            ah3_reg <= plan.accel * x2_reg[TIME_W-1:32];
            al3_reg <= plan.accel * x2_reg[31:0];
            ch3_reg <= plan.vpeak * dt2_reg[TIME_W-1:32];
            cl3_reg <= plan.vpeak * dt2_reg[31:0];
            x3_reg  <= x2_reg;
            ph3_reg <= ph2_reg;
        end
        if (en[4])
        begin
            sp4_reg <= TIME_W'(ah3_reg) + TIME_W'(al3_reg[62:32]);
            c4_reg  <= TIME_W'(ch3_reg) + TIME_W'(cl3_reg[62:32]);
            x4_reg  <= x3_reg;
            ph4_reg <= ph3_reg;
        end
        if (en[5])
        begin
            qh5_reg <= sp4_reg[31:0] * x4_reg[TIME_W-1:32];
            ql5_reg <= sp4_reg[31:0] * x4_reg[31:0];
            c5_reg  <= c4_reg;
            ph5_reg <= ph4_reg;
        end
        if (en[6])
        begin
            q6_reg  <= q_sum[TIME_W:1];
            c6_reg  <= c5_reg;
            ph6_reg <= ph5_reg;
        end
        if (en[7])
        begin
            ph7_reg <= ph6_reg;
            if (ph6_reg == PH_DONE)
                pos_reg <= plan.target;
            else
                pos_reg <= plan.neg ? 32'(-m32) : m32;
        end
    end

    assign out_ch.valid             = valid_reg[NST];
    assign out_ch.position_setpoint = pos_reg;
    assign out_ch.phase             = ph7_reg;

endmodule

FILE: rtl/trapezoid_distance_profile.sv
// Top level of the trapezoidal move position setpoint generator.
//
// Configuration: write cfg_data to register cfg_index when cfg_we is high
// (0 target distance, 1 peak speed, 2 acceleration, 3 tick period).
// Each write restarts the planner, which derives peak speed and phase
// times with a bit-serial square root and long division. Input ready
// stays low while the plan is computed. The same pass runs after reset.
// Input channel in_ch carries a tick index; output channel out_ch returns
// the position setpoint and phase code for that tick.
// Each item passes the seven pipeline stages from input accept to output valid.
// Throughput: one item per cycle once the plan is ready and the receiver does
// not stall; the pipeline with its 32x32 multiplier stages sets this.
// When the receiver stalls, items hold in place and empty stages still
// fill, so input ready drops only once the pipeline is full.
// Reset clears all valid bits and loads the register reset values.
module trapezoid_distance_profile (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [tdp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tdp_pkg::CFG_DATA_W-1:0] cfg_data,
    tdp_in_if.sink                         in_ch,
    tdp_out_if.source                      out_ch
);
    import tdp_pkg::*;

    plan_t plan;

    tdp_plan u_plan (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .plan      (plan)
    );

    tdp_pipe u_pipe (
        .clk    (clk),
        .rst_n  (rst_n),
        .plan   (plan),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

endmodule

FILE: rtl/tdp_check.sv
// Port-level assertions for the profile block and their bind.
module tdp_check (
    input logic        clk,
    input logic        rst_n,
    input logic        cfg_we,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] out_pos,
    input logic [1:0]  out_phase
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output item dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_pos) && $stable(out_phase))
        else $error("output item changed while stalled");

    a_cfg_block: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> !in_ready)
        else $error("input taken right after a register write");

    a_cfg_plan: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |-> ##2 !in_ready)
        else $error("planner finished too early");

endmodule

bind trapezoid_distance_profile tdp_check u_tdp_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_pos   (out_ch.position_setpoint),
    .out_phase (out_ch.phase)
);
